/* rtl/assert_macros.svh */
// Assertion macros shared by the polar/Cartesian converter RTL.
// Each macro expects signals named clock and reset in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define PCC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Property checked at every rising clock edge, reset included.
`define PCC_ASSERT_ALL(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* rtl/pcc_pkg.sv */
// Shared types, constants and the arctangent table of the polar/Cartesian converter.
// No dependencies; every RTL module imports this package.
`default_nettype none

package pcc_pkg;

   // Operand and result formats.
   localparam int COORD_WIDTH        = 16;
   localparam int OUT_WIDTH          = COORD_WIDTH + 1;
   localparam int ITERATIONS_DEFAULT = 16;

   // Datapath x/y carry GUARD fraction bits; angles run in units of 2^-24 rad.
   localparam int GUARD           = 16;
   localparam int XW              = 35;
   localparam int ZW              = 28;
   localparam int ANGLE_IN_SHIFT  = 11;
   localparam int ANGLE_OUT_SHIFT = 11;

   // Gain compensation: v * INV_GAIN / 2^30, kept with GUARD fraction bits.
   localparam int GAIN_WIDTH     = 31;
   localparam int PRESCALE_SHIFT = 30 - GUARD;
   localparam int PROD_WIDTH     = COORD_WIDTH + 1 + GAIN_WIDTH;
   localparam logic signed [GAIN_WIDTH-1:0] INV_GAIN = 31'sd652032874;

   localparam logic signed [ZW-1:0] PI_Z      = 28'sd52707179;
   localparam logic signed [ZW-1:0] TWO_PI_Z  = 28'sd105414357;
   localparam logic signed [ZW-1:0] HALF_PI_Z = 28'sd26353590;

   localparam int ATAN_ENTRIES = 24;
   localparam logic signed [ZW-1:0] ATAN_TAB [ATAN_ENTRIES] = '{
      28'sd13176795, 28'sd7778716, 28'sd4110060, 28'sd2086331,
      28'sd1047214,  28'sd524117,  28'sd262123,  28'sd131069,
      28'sd65536,    28'sd32768,   28'sd16384,   28'sd8192,
      28'sd4096,     28'sd2048,    28'sd1024,    28'sd512,
      28'sd256,      28'sd128,     28'sd64,      28'sd32,
      28'sd16,       28'sd8,       28'sd4,       28'sd2
   };

   typedef enum logic {
      REQ_TO_POLAR = 1'b0,
      REQ_TO_CART  = 1'b1
   } req_kind_type;

   // One request in flight between the front end, the rotation cells and the back end.
   typedef struct packed {
      req_kind_type           mode;
      logic                   zero;
      logic                   neg;
      logic signed [XW-1:0]   x;
      logic signed [XW-1:0]   y;
      logic signed [ZW-1:0]   z;
   } pcc_item_type;

endpackage

`default_nettype wire

/* rtl/pcc_cell.sv */
// One CORDIC micro-rotation stage with its own pipeline register.
// Depends on pcc_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module pcc_cell import pcc_pkg::*; #(
   parameter int SHIFT = 0
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         up_valid,
   output logic              up_ready,
   input  wire pcc_item_type up_item,
   output logic              dn_valid,
   input  wire logic         dn_ready,
   output pcc_item_type      dn_item
);

   localparam int ANGLE_INDEX = (SHIFT < ATAN_ENTRIES) ? SHIFT : ATAN_ENTRIES - 1;
   localparam logic signed [ZW-1:0] ANGLE_STEP = ATAN_TAB[ANGLE_INDEX];

   logic                 valid_ff, valid_in;
   pcc_item_type         item_ff, item_in;
   logic signed [XW-1:0] x_sh, y_sh;
   logic                 turn_neg;

   // Rotation mode drives z toward zero, vectoring mode drives y toward zero.
   always_comb begin
      x_sh     = up_item.x >>> SHIFT;
      y_sh     = up_item.y >>> SHIFT;
      turn_neg = (up_item.mode == REQ_TO_CART) ? !up_item.z[ZW-1] : up_item.y[XW-1];
      item_in  = up_item;
      if (turn_neg) begin
         item_in.x = up_item.x - y_sh;
         item_in.y = up_item.y + x_sh;
         item_in.z = up_item.z - ANGLE_STEP;
      end else begin
         item_in.x = up_item.x + y_sh;
         item_in.y = up_item.y - x_sh;
         item_in.z = up_item.z + ANGLE_STEP;
      end
   end

   assign up_ready = !valid_ff || dn_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         item_ff <= item_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_item  = item_ff;

   `PCC_ASSERT(a_cell_hold, valid_ff && !dn_ready |=> valid_ff && $stable(item_ff), "cell lost a stalled request")

endmodule

`default_nettype wire

/* rtl/pcc_prep.sv */
// Front end: quadrant correction and angle reduction, then gain prescaling.
// Two pipeline registers; depends on pcc_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module pcc_prep import pcc_pkg::*; (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic                          req_type,
   input  wire logic signed [COORD_WIDTH-1:0] req_in_first,
   input  wire logic signed [COORD_WIDTH-1:0] req_in_second,
   output logic                               dn_valid,
   input  wire logic                          dn_ready,
   output pcc_item_type                       dn_item
);

   // First stage registers.
   logic                         v1_ff, v1_in;
   req_kind_type                 mode1_ff, mode1_in;
   logic                         zero1_ff, zero1_in;
   logic signed [COORD_WIDTH:0]  a1_ff, a1_in;
   logic signed [COORD_WIDTH:0]  b1_ff, b1_in;
   logic signed [ZW-1:0]         z1_ff, z1_in;
   logic                         ready1;

   // Second stage registers.
   logic                         v2_ff, v2_in;
   pcc_item_type                 item_ff, item_in;
   logic                         ready2;

   logic signed [COORD_WIDTH:0]  a_ext, b_ext;
   logic                         flip;
   logic signed [ZW-1:0]         z_raw;
   logic signed [PROD_WIDTH-1:0] prod_a, prod_b;

   // Stage one: the to-polar path mirrors left-half-plane vectors by pi; the
   // to-Cartesian path wraps the angle into (-pi, pi].
   always_comb begin
      mode1_in = req_kind_type'(req_type);
      a_ext    = (COORD_WIDTH + 1)'(req_in_first);
      b_ext    = (COORD_WIDTH + 1)'(req_in_second);
      flip     = (mode1_in == REQ_TO_POLAR) && a_ext[COORD_WIDTH];
      a1_in    = flip ? -a_ext : a_ext;
      b1_in    = flip ? -b_ext : b_ext;
      zero1_in = (mode1_in == REQ_TO_POLAR) && (a_ext == '0) && (b_ext == '0);
      z_raw    = ZW'(req_in_second) <<< ANGLE_IN_SHIFT;
      unique case (mode1_in)
         REQ_TO_POLAR: begin
            if (!flip) begin
               z1_in = '0;
            end else if (!b_ext[COORD_WIDTH]) begin
               z1_in = PI_Z;
            end else begin
               z1_in = -PI_Z;
            end
         end
         REQ_TO_CART: begin
            if (z_raw > PI_Z) begin
               z1_in = z_raw - TWO_PI_Z;
            end else if (z_raw <= -PI_Z) begin
               z1_in = z_raw + TWO_PI_Z;
            end else begin
               z1_in = z_raw;
            end
         end
         default: z1_in = '0;
      endcase
   end

   // Stage two: remove the CORDIC gain in advance and fold the angle into
   // [-pi/2, pi/2], remembering to negate the result.
   assign prod_a = PROD_WIDTH'(a1_ff) * PROD_WIDTH'(INV_GAIN);
   assign prod_b = PROD_WIDTH'(b1_ff) * PROD_WIDTH'(INV_GAIN);

   always_comb begin
      item_in.mode = mode1_ff;
      item_in.zero = zero1_ff;
      item_in.neg  = 1'b0;
      item_in.z    = z1_ff;
      item_in.x    = XW'((prod_a + PROD_WIDTH'(1 << (PRESCALE_SHIFT - 1))) >>> PRESCALE_SHIFT);
      item_in.y    = '0;
      if (mode1_ff == REQ_TO_POLAR) begin
         item_in.y = XW'((prod_b + PROD_WIDTH'(1 << (PRESCALE_SHIFT - 1))) >>> PRESCALE_SHIFT);
      end else if (z1_ff > HALF_PI_Z) begin
         item_in.z   = z1_ff - PI_Z;
         item_in.neg = 1'b1;
      end else if (z1_ff < -HALF_PI_Z) begin
         item_in.z   = z1_ff + PI_Z;
         item_in.neg = 1'b1;
      end
   end

   assign ready2    = !v2_ff || dn_ready;
   assign ready1    = !v1_ff || ready2;
   assign req_ready = ready1;
   assign v1_in     = ready1 ? req_valid : v1_ff;
   assign v2_in     = ready2 ? v1_ff : v2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ready1 && req_valid) begin
         mode1_ff <= mode1_in;
         zero1_ff <= zero1_in;
         a1_ff    <= a1_in;
         b1_ff    <= b1_in;
         z1_ff    <= z1_in;
      end
      if (ready2 && v1_ff) begin
         item_ff <= item_in;
      end
   end

   assign dn_valid = v2_ff;
   assign dn_item  = item_ff;

   `PCC_ASSERT(a_polar_right_half, v1_ff && (mode1_ff == REQ_TO_POLAR) |-> !a1_ff[COORD_WIDTH], "mirrored x is negative")
   `PCC_ASSERT(a_fold_range, v2_ff && (item_ff.mode == REQ_TO_CART) |-> (item_ff.z <= HALF_PI_Z) && (item_ff.z >= -HALF_PI_Z), "folded angle outside half circle")

endmodule

`default_nettype wire

/* rtl/pcc_post.sv */
// Back end: undo the angle fold, round, saturate and hold the result register.
// Two pipeline registers; depends on pcc_pkg.
`default_nettype none

module pcc_post import pcc_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    up_valid,
   output logic                         up_ready,
   input  wire pcc_item_type            up_item,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic signed [OUT_WIDTH-1:0]  rsp_out_first,
   output logic signed [OUT_WIDTH-1:0]  rsp_out_second
);

   localparam int SW = XW + 1;
   localparam logic signed [SW-1:0] SAT_HI = SW'((1 << COORD_WIDTH) - 1);
   localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);

   logic                        v1_ff, v1_in;
   pcc_item_type                item1_ff, item1_in;
   logic                        v2_ff, v2_in;
   logic signed [OUT_WIDTH-1:0] first_ff, first_in;
   logic signed [OUT_WIDTH-1:0] second_ff, second_in;
   logic                        ready2;
   logic signed [SW-1:0]        rx, ry, rz;

   function automatic logic signed [OUT_WIDTH-1:0] saturate(input logic signed [SW-1:0] v);
      logic signed [OUT_WIDTH-1:0] r;
      if (v > SAT_HI) begin
         r = SAT_HI[OUT_WIDTH-1:0];
      end else if (v < SAT_LO) begin
         r = SAT_LO[OUT_WIDTH-1:0];
      end else begin
         r = v[OUT_WIDTH-1:0];
      end
      return r;
   endfunction

   always_comb begin
      item1_in = up_item;
      if (up_item.neg) begin
         item1_in.x = -up_item.x;
         item1_in.y = -up_item.y;
      end
   end

   // Round half up, then clamp to the result width.
   always_comb begin
      rx = (SW'(item1_ff.x) + SW'(1 << (GUARD - 1))) >>> GUARD;
      ry = (SW'(item1_ff.y) + SW'(1 << (GUARD - 1))) >>> GUARD;
      rz = (SW'(item1_ff.z) + SW'(1 << (ANGLE_OUT_SHIFT - 1))) >>> ANGLE_OUT_SHIFT;
      if (item1_ff.zero) begin
         first_in  = '0;
         second_in = '0;
      end else begin
         first_in  = saturate(rx);
         second_in = (item1_ff.mode == REQ_TO_CART) ? saturate(ry) : saturate(rz);
      end
   end

   assign ready2   = !v2_ff || rsp_ready;
   assign up_ready = !v1_ff || ready2;
   assign v1_in    = up_ready ? up_valid : v1_ff;
   assign v2_in    = ready2 ? v1_ff : v2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         item1_ff <= item1_in;
      end
      if (ready2 && v1_ff) begin
         first_ff  <= first_in;
         second_ff <= second_in;
      end
   end

   assign rsp_valid      = v2_ff;
   assign rsp_out_first  = first_ff;
   assign rsp_out_second = second_ff;

endmodule

`default_nettype wire

/* rtl/polar_cartesian_converter.sv */
// Top level of the CORDIC polar/Cartesian converter.
// Depends on pcc_pkg, pcc_prep, pcc_cell, pcc_post and assert_macros.svh.
//
//   Channel   Direction   Handshake            Payload
//   req_      in          req_valid/req_ready  req_type, req_in_first, req_in_second
//   rsp_      out         rsp_valid/rsp_ready  rsp_out_first, rsp_out_second
//
// A request passes through two front-end stages, one rotation cell per iteration
// and two back-end stages before its result is valid. Unless the output stalls,
// the pipeline takes a new request in every cycle; throughput is one per clock.
// Reset is synchronous and clears only the stage valid bits.
// A stalled result holds its stage; stages upstream keep moving into empty
// slots, so requests are still taken while the pipeline has a bubble.
`default_nettype none
`include "assert_macros.svh"

module polar_cartesian_converter import pcc_pkg::*; #(
   parameter int ITERATIONS = ITERATIONS_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic                          req_type,
   input  wire logic signed [COORD_WIDTH-1:0] req_in_first,
   input  wire logic signed [COORD_WIDTH-1:0] req_in_second,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic signed [OUT_WIDTH-1:0]        rsp_out_first,
   output logic signed [OUT_WIDTH-1:0]        rsp_out_second
);

   // Link k feeds cell k; link ITERATIONS feeds the back end.
   logic [ITERATIONS:0] link_valid;
   logic [ITERATIONS:0] link_ready;
   pcc_item_type        link_item [ITERATIONS+1];

   // Front end: quadrant mirror or angle wrap, then gain prescaling.
   pcc_prep u_prep (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_type      (req_type),
      .req_in_first  (req_in_first),
      .req_in_second (req_in_second),
      .dn_valid      (link_valid[0]),
      .dn_ready      (link_ready[0]),
      .dn_item       (link_item[0])
   );

   // The chain of micro-rotation cells, one shift amount per cell.
   for (genvar k = 0; k < ITERATIONS; k++) begin : g_cell
      pcc_cell #(
         .SHIFT (k)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (link_valid[k]),
         .up_ready (link_ready[k]),
         .up_item  (link_item[k]),
         .dn_valid (link_valid[k+1]),
         .dn_ready (link_ready[k+1]),
         .dn_item  (link_item[k+1])
      );
   end

   // Back end: undo the fold, round, saturate and present the result.
   pcc_post u_post (
      .clock          (clock),
      .reset          (reset),
      .up_valid       (link_valid[ITERATIONS]),
      .up_ready       (link_ready[ITERATIONS]),
      .up_item        (link_item[ITERATIONS]),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_first  (rsp_out_first),
      .rsp_out_second (rsp_out_second)
   );

   // After reset no result is shown.
   `PCC_ASSERT_ALL(a_reset_idle, reset |=> !rsp_valid, "result valid right after reset")
   // The input can only be refused when every stage is full and the output is stalled.
   `PCC_ASSERT(a_refuse_only_full, !req_ready |-> rsp_valid && !rsp_ready && (&link_valid[ITERATIONS:1]), "request refused with room in the pipeline")

endmodule

`default_nettype wire
